/* sv/pkfd_pkg.sv */
// Shared types and constants for the per-key flood detector.
// Depends on nothing; every other file refers to it by scoped names.
package pkfd_pkg;

   localparam int NUM_ENTRIES = 16;
   localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int SCAN_W      = $clog2(NUM_ENTRIES + 1);

   localparam int KEY_W    = 64;
   localparam int TIME_W   = 32;
   localparam int COUNT_W  = 8;
   localparam int WINDOW_W = 16;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_SECONDS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ALERT_COUNT    = 1'd1;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd60;
   localparam logic [COUNT_W-1:0]  ALERT_RESET  = 8'd5;
   localparam logic [COUNT_W-1:0]  COUNT_MAX    = 8'd255;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_INSERT = 4'b0100,
      S_WAIT   = 4'b1000
   } state_type;

   // Write request into the entry table.
   typedef struct packed {
      logic             wr_entry;   // write last time and count
      logic             wr_key;     // write the key as well
      logic             set_valid;
      logic             clr_valid;
      logic [IDX_W-1:0] idx;
   } tbl_op_type;

   // Verdict of the shared compare and aging unit on one entry.
   typedef struct packed {
      logic               match;
      logic               stale;
      logic               alert;
      logic [COUNT_W-1:0] new_count;
   } entry_eval_type;

endpackage

/* sv/pkfd_entry_unit.sv */
// Shared compare and aging unit: matches one table entry against the event key,
// checks staleness and forms the updated count. Depends on pkfd_pkg.
module pkfd_entry_unit (
   input  logic                          entry_valid,
   input  logic [pkfd_pkg::KEY_W-1:0]    entry_key,
   input  logic [pkfd_pkg::TIME_W-1:0]   entry_last_time,
   input  logic [pkfd_pkg::COUNT_W-1:0]  entry_count,
   input  logic [pkfd_pkg::KEY_W-1:0]    event_key,
   input  logic [pkfd_pkg::TIME_W-1:0]   event_time,
   input  logic [pkfd_pkg::WINDOW_W-1:0] window_seconds,
   input  logic [pkfd_pkg::COUNT_W-1:0]  alert_count,
   output pkfd_pkg::entry_eval_type      eval
);

   logic [pkfd_pkg::TIME_W:0]    expiry;
   logic [pkfd_pkg::COUNT_W-1:0] base_count;

   // The expiry sum is one bit wider so that it never wraps.
   assign expiry = {1'b0, entry_last_time}
                 + {{(pkfd_pkg::TIME_W + 1 - pkfd_pkg::WINDOW_W){1'b0}}, window_seconds};

   always_comb begin
      eval.match = entry_valid && (entry_key == event_key);
      eval.stale = expiry < {1'b0, event_time};
      base_count = eval.stale ? '0 : entry_count;
      if (base_count == pkfd_pkg::COUNT_MAX) begin
         eval.new_count = pkfd_pkg::COUNT_MAX;
      end else begin
         eval.new_count = base_count + 1'b1;
      end
      eval.alert = eval.match && (eval.new_count >= alert_count);
   end

endmodule

/* sv/pkfd_table.sv */
// Entry table: valid bits in reset flops, key, last-seen time and count per slot.
// One read address and one write port per cycle. Depends on pkfd_pkg.
module pkfd_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [pkfd_pkg::IDX_W-1:0]        rd_idx,
   output logic                              rd_valid,
   output logic [pkfd_pkg::KEY_W-1:0]        rd_key,
   output logic [pkfd_pkg::TIME_W-1:0]       rd_last_time,
   output logic [pkfd_pkg::COUNT_W-1:0]      rd_count,
   input  pkfd_pkg::tbl_op_type              op,
   input  logic [pkfd_pkg::KEY_W-1:0]        wr_key_data,
   input  logic [pkfd_pkg::TIME_W-1:0]       wr_time_data,
   input  logic [pkfd_pkg::COUNT_W-1:0]      wr_count_data
);

   logic [pkfd_pkg::NUM_ENTRIES-1:0] valid_ff;
   logic [pkfd_pkg::NUM_ENTRIES-1:0] valid_in;
   logic [pkfd_pkg::KEY_W-1:0]       key_ff   [pkfd_pkg::NUM_ENTRIES];
   logic [pkfd_pkg::TIME_W-1:0]      last_ff  [pkfd_pkg::NUM_ENTRIES];
   logic [pkfd_pkg::COUNT_W-1:0]     count_ff [pkfd_pkg::NUM_ENTRIES];

   always_comb begin
      valid_in = valid_ff;
      if (op.set_valid) begin
         valid_in[op.idx] = 1'b1;
      end else if (op.clr_valid) begin
         valid_in[op.idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (op.wr_entry) begin
         last_ff[op.idx]  <= wr_time_data;
         count_ff[op.idx] <= wr_count_data;
         if (op.wr_key) begin
            key_ff[op.idx] <= wr_key_data;
         end
      end
   end

   assign rd_valid     = valid_ff[rd_idx];
   assign rd_key       = key_ff[rd_idx];
   assign rd_last_time = last_ff[rd_idx];
   assign rd_count     = count_ff[rd_idx];

endmodule

/* sv/per_key_flood_detector_core.sv */
// Per-key flood detector: top level with the scan sequencer and result register.
// Depends on pkfd_pkg, pkfd_entry_unit and pkfd_table.
//
// Each event transaction is accepted in the idle state; in the scan state the shared
// compare and aging unit then visits every table slot in order, and the insert step
// stores a new key if it was not found and a slot is free, and registers the
// result. The block is ready again once the result is registered; if the previous
// result has not been taken yet, the insert step waits for the response slot.
// Configuration writes land at once and should be made between events.
module per_key_flood_detector_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [pkfd_pkg::KEY_W-1:0]          req_source_key,
   input  logic [pkfd_pkg::TIME_W-1:0]         req_event_time,
   input  logic                                req_is_local,
   input  logic                                req_is_excluded,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_flood_alert,
   output logic                                rsp_take_action,
   output logic                                rsp_table_full,
   input  logic                                csr_write_enable,
   input  logic [pkfd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pkfd_pkg::CSR_W-1:0]          csr_write_data
);

   pkfd_pkg::state_type state_ff, state_in;

   logic [pkfd_pkg::WINDOW_W-1:0] window_ff;
   logic [pkfd_pkg::COUNT_W-1:0]  alert_count_ff;

   logic [pkfd_pkg::KEY_W-1:0]    key_ff;
   logic [pkfd_pkg::TIME_W-1:0]   now_ff;
   logic                          local_ff;
   logic                          excl_ff;

   logic [pkfd_pkg::SCAN_W-1:0]   scan_ff, scan_in;
   logic                          found_ff, found_in;
   logic                          alert_ff, alert_in;
   logic                          free_found_ff, free_found_in;
   logic [pkfd_pkg::IDX_W-1:0]    free_idx_ff, free_idx_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_alert_ff, rsp_action_ff, rsp_full_ff;

   logic [pkfd_pkg::IDX_W-1:0]    scan_idx;
   logic                          scan_last;
   logic                          rsp_free;
   logic                          req_fire;

   logic                          rd_valid;
   logic [pkfd_pkg::KEY_W-1:0]    rd_key;
   logic [pkfd_pkg::TIME_W-1:0]   rd_last_time;
   logic [pkfd_pkg::COUNT_W-1:0]  rd_count;
   pkfd_pkg::entry_eval_type      eval;
   pkfd_pkg::tbl_op_type          tbl_op;
   logic [pkfd_pkg::COUNT_W-1:0]  wr_count;

   assign scan_idx  = scan_ff[pkfd_pkg::IDX_W-1:0];
   assign scan_last = (scan_ff == pkfd_pkg::SCAN_W'(pkfd_pkg::NUM_ENTRIES - 1));
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == pkfd_pkg::S_IDLE);
   assign req_fire  = req_valid && req_ready;

   pkfd_table u_table (
      .clock         (clock),
      .reset         (reset),
      .rd_idx        (scan_idx),
      .rd_valid      (rd_valid),
      .rd_key        (rd_key),
      .rd_last_time  (rd_last_time),
      .rd_count      (rd_count),
      .op            (tbl_op),
      .wr_key_data   (key_ff),
      .wr_time_data  (now_ff),
      .wr_count_data (wr_count)
   );

   pkfd_entry_unit u_unit (
      .entry_valid     (rd_valid),
      .entry_key       (rd_key),
      .entry_last_time (rd_last_time),
      .entry_count     (rd_count),
      .event_key       (key_ff),
      .event_time      (now_ff),
      .window_seconds  (window_ff),
      .alert_count     (alert_count_ff),
      .eval            (eval)
   );

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      found_in      = found_ff;
      alert_in      = alert_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      tbl_op        = '0;
      wr_count      = eval.new_count;

      unique case (state_ff)
         pkfd_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in      = pkfd_pkg::S_SCAN;
               scan_in       = '0;
               found_in      = 1'b0;
               alert_in      = 1'b0;
               free_found_in = 1'b0;
               free_idx_in   = '0;
            end
         end
         pkfd_pkg::S_SCAN: begin
            tbl_op.idx = scan_idx;
            if (eval.match) begin
               tbl_op.wr_entry = 1'b1;
               found_in        = 1'b1;
               alert_in        = alert_ff || eval.alert;
            end else if (rd_valid && eval.stale) begin
               tbl_op.clr_valid = 1'b1;
            end
            // A slot freed by aging counts as free for the insert that follows.
            if (!free_found_ff && (!rd_valid || (!eval.match && eval.stale))) begin
               free_found_in = 1'b1;
               free_idx_in   = scan_idx;
            end
            if (scan_last) begin
               state_in = pkfd_pkg::S_INSERT;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         pkfd_pkg::S_INSERT: begin
            tbl_op.idx = free_idx_ff;
            wr_count   = '0;
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = pkfd_pkg::S_IDLE;
               if (!found_ff && free_found_ff) begin
                  tbl_op.wr_entry  = 1'b1;
                  tbl_op.wr_key    = 1'b1;
                  tbl_op.set_valid = 1'b1;
               end
            end
         end
         pkfd_pkg::S_WAIT: begin
            state_in = pkfd_pkg::S_IDLE;
         end
         default: begin
            state_in = pkfd_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= pkfd_pkg::S_IDLE;
         rsp_valid_ff   <= 1'b0;
         window_ff      <= pkfd_pkg::WINDOW_RESET;
         alert_count_ff <= pkfd_pkg::ALERT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               pkfd_pkg::REG_WINDOW_SECONDS: window_ff <= csr_write_data;
               pkfd_pkg::REG_ALERT_COUNT:
                  alert_count_ff <= csr_write_data[pkfd_pkg::COUNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      found_ff      <= found_in;
      alert_ff      <= alert_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      if (req_fire) begin
         key_ff   <= req_source_key;
         now_ff   <= req_event_time;
         local_ff <= req_is_local;
         excl_ff  <= req_is_excluded;
      end
      if ((state_ff == pkfd_pkg::S_INSERT) && rsp_free) begin
         rsp_alert_ff  <= alert_ff;
         rsp_action_ff <= alert_ff && local_ff && !excl_ff;
         rsp_full_ff   <= !found_ff && !free_found_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_flood_alert = rsp_alert_ff;
   assign rsp_take_action = rsp_action_ff;
   assign rsp_table_full  = rsp_full_ff;

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == pkfd_pkg::S_SCAN) && (scan_ff == '0))
      else $error("accepted event did not start a scan at slot zero");

   a_scan_ends_in_insert: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == pkfd_pkg::S_SCAN) && scan_last) |=> (state_ff == pkfd_pkg::S_INSERT))
      else $error("scan did not end in the insert step");

   a_no_insert_on_match: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == pkfd_pkg::S_INSERT) && found_ff) |-> !tbl_op.set_valid)
      else $error("a matched key was inserted a second time");

   a_result_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_full_ff && rsp_alert_ff) && !(rsp_action_ff && !rsp_alert_ff))
      else $error("result fields contradict each other");

   a_result_after_insert: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == pkfd_pkg::S_INSERT))
      else $error("result appeared outside the insert step");

endmodule

/* test/tb_per_key_flood_detector_core.sv */
// Testbench for per_key_flood_detector_core: sends event transactions, predicts each
// verdict from its own copy of the key table and compares every response field by field.
// Depends on pkfd_pkg and the detector RTL.
module tb_per_key_flood_detector_core;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic flood_alert;
      logic take_action;
      logic table_full;
   } verdict_type;

   localparam int POOL_SIZE = 20;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [pkfd_pkg::KEY_W-1:0]     req_source_key = '0;
   logic [pkfd_pkg::TIME_W-1:0]    req_event_time = '0;
   logic                           req_is_local = 1'b0;
   logic                           req_is_excluded = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic                           rsp_flood_alert;
   logic                           rsp_take_action;
   logic                           rsp_table_full;
   logic                           csr_write_enable = 1'b0;
   logic [pkfd_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [pkfd_pkg::CSR_W-1:0]     csr_write_data = '0;

   // Shadow of the detector: configuration and key table.
   logic [pkfd_pkg::WINDOW_W-1:0]  window_cfg = pkfd_pkg::WINDOW_RESET;
   logic [pkfd_pkg::COUNT_W-1:0]   limit_cfg = pkfd_pkg::ALERT_RESET;
   logic                           tbl_valid [pkfd_pkg::NUM_ENTRIES] = '{default: 1'b0};
   logic [pkfd_pkg::KEY_W-1:0]     tbl_key   [pkfd_pkg::NUM_ENTRIES];
   logic [pkfd_pkg::TIME_W-1:0]    tbl_last  [pkfd_pkg::NUM_ENTRIES];
   logic [pkfd_pkg::COUNT_W-1:0]   tbl_count [pkfd_pkg::NUM_ENTRIES];

   verdict_type          pending_verdicts [$];
   verdict_type          expected_verdict;
   int                   error_count = 0;
   int                   send_idle_pct = 19;
   int                   recv_stall_pct = 66;

   per_key_flood_detector_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_source_key   (req_source_key),
      .req_event_time   (req_event_time),
      .req_is_local     (req_is_local),
      .req_is_excluded  (req_is_excluded),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_flood_alert  (rsp_flood_alert),
      .rsp_take_action  (rsp_take_action),
      .rsp_table_full   (rsp_table_full),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #4;
      clock = 1'b1;
      #4;
      clock = 1'b0;
   end

   // The sum is taken one bit wider so that a late last-seen time never wraps.
   function automatic logic aged_out(input logic [pkfd_pkg::TIME_W-1:0] last_seen,
                                     input logic [pkfd_pkg::TIME_W-1:0] evt_time);
      return ({1'b0, last_seen}
              + {{(pkfd_pkg::TIME_W + 1 - pkfd_pkg::WINDOW_W){1'b0}}, window_cfg})
             < {1'b0, evt_time};
   endfunction

   function automatic verdict_type predict_verdict(input logic [pkfd_pkg::KEY_W-1:0] key,
                                                   input logic [pkfd_pkg::TIME_W-1:0] evt_time,
                                                   input logic from_local,
                                                   input logic excluded);
      verdict_type v;
      logic        found;
      logic        stored;
      v = '0;
      found = 1'b0;
      for (int i = 0; i < pkfd_pkg::NUM_ENTRIES; i++) begin
         if (tbl_valid[i]) begin
            if (tbl_key[i] == key) begin
               found = 1'b1;
               if (aged_out(tbl_last[i], evt_time)) begin
                  tbl_count[i] = '0;
               end
               if (tbl_count[i] != pkfd_pkg::COUNT_MAX) begin
                  tbl_count[i] = tbl_count[i] + 1'b1;
               end
               tbl_last[i] = evt_time;
               if (tbl_count[i] >= limit_cfg) begin
                  v.flood_alert = 1'b1;
               end
            end else if (aged_out(tbl_last[i], evt_time)) begin
               tbl_valid[i] = 1'b0;
            end
         end
      end
      if (!found) begin
         stored = 1'b0;
         for (int i = 0; i < pkfd_pkg::NUM_ENTRIES; i++) begin
            if (!stored && !tbl_valid[i]) begin
               tbl_valid[i] = 1'b1;
               tbl_key[i]   = key;
               tbl_last[i]  = evt_time;
               tbl_count[i] = '0;
               stored = 1'b1;
            end
         end
         v.table_full = !stored;
      end
      v.take_action = v.flood_alert && from_local && !excluded;
      return v;
   endfunction

   // Mostly short steps so that counts build up, now and then a jump to or past the window.
   function automatic logic [pkfd_pkg::TIME_W-1:0] time_step();
      int w;
      int roll;
      w = int'(window_cfg);
      roll = $urandom_range(0, 19);
      if (roll == 0) begin
         return w;
      end else if (roll == 1) begin
         return w + 1;
      end else if (roll < 4) begin
         return $urandom_range(0, 3 * w + 3);
      end
      return $urandom_range(0, w / (int'(limit_cfg) + 1));
   endfunction

   task automatic check_bit(input string field, input logic exp_bit, input logic act_bit);
      if (exp_bit !== act_bit) begin
         $display("%0t ns: %s mismatch, expected %0b, actual %0b",
                  $time, field, exp_bit, act_bit);
         error_count++;
      end
   endtask

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t ns: response with no event outstanding, expected none, actual %0b%0b%0b",
                     $time, rsp_flood_alert, rsp_take_action, rsp_table_full);
            error_count++;
         end else begin
            expected_verdict = pending_verdicts.pop_front();
            check_bit("flood_alert", expected_verdict.flood_alert, rsp_flood_alert);
            check_bit("take_action", expected_verdict.take_action, rsp_take_action);
            check_bit("table_full", expected_verdict.table_full, rsp_table_full);
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the transaction.
   task automatic send_event(input logic [pkfd_pkg::KEY_W-1:0] key,
                             input logic [pkfd_pkg::TIME_W-1:0] evt_time,
                             input logic from_local, input logic excluded);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_source_key  = key;
      req_event_time  = evt_time;
      req_is_local    = from_local;
      req_is_excluded = excluded;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_verdicts = {pending_verdicts,
                          predict_verdict(key, evt_time, from_local, excluded)};
      @(negedge clock);
   endtask

   task automatic wait_until_drained();
      req_valid = 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clock);
      repeat (pkfd_pkg::NUM_ENTRIES + 4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [pkfd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [pkfd_pkg::CSR_W-1:0] data);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      if (idx == pkfd_pkg::REG_WINDOW_SECONDS) begin
         window_cfg = data[pkfd_pkg::WINDOW_W-1:0];
      end else if (idx == pkfd_pkg::REG_ALERT_COUNT) begin
         limit_cfg = data[pkfd_pkg::COUNT_W-1:0];
      end
   endtask

   // Reset settings: alert on the fifth match, the window edge, staleness, a key at the
   // last second of time, and a table filled until a new key is refused.
   task automatic test_alert_and_table_fill();
      send_event('0, 32'd0, 1'b0, 1'b0);
      for (int i = 1; i <= 5; i++) begin
         send_event('0, 32'd10 * i, 1'b1, 1'b0);
      end
      send_event('0, 32'd110, 1'b1, 1'b1);
      send_event('0, 32'd171, 1'b0, 1'b1);
      send_event('1, 32'hFFFF_FFFF, 1'b1, 1'b0);
      for (int i = 0; i < pkfd_pkg::NUM_ENTRIES; i++) begin
         send_event(64'd1 << (4 * i + 1), 32'd200, i[0], i[1]);
      end
      wait_until_drained();
   endtask

   // A zero window makes every older entry stale; a limit of one alerts on each match.
   task automatic test_zero_window_min_limit();
      write_csr(pkfd_pkg::REG_WINDOW_SECONDS, 16'd0);
      write_csr(pkfd_pkg::REG_ALERT_COUNT, 16'd1);
      send_event('1, 32'd300, 1'b1, 1'b0);
      send_event(64'hDEAD_BEEF_0123_4567, 32'd300, 1'b1, 1'b0);
      send_event(64'hDEAD_BEEF_0123_4567, 32'd300, 1'b0, 1'b0);
      send_event(64'hDEAD_BEEF_0123_4567, 32'd301, 1'b1, 1'b1);
      send_event(64'h0123_4567_89AB_CDEF, 32'd301, 1'b1, 1'b0);
      wait_until_drained();
   endtask

   // Widest window and highest limit: the count climbs to its ceiling and stays there until the entry ages out.
   task automatic test_count_saturation();
      logic [pkfd_pkg::KEY_W-1:0]  key;
      logic [pkfd_pkg::TIME_W-1:0] first_seen;
      key = {$urandom, $urandom};
      first_seen = 32'h8000_0000 | $urandom_range(0, 1000);
      write_csr(pkfd_pkg::REG_WINDOW_SECONDS, 16'hFFFF);
      write_csr(pkfd_pkg::REG_ALERT_COUNT, 16'd255);
      for (int i = 0; i < 258; i++) begin
         send_event(key, first_seen, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      send_event(key, first_seen + 32'd65535, 1'b1, 1'b0);
      send_event(key, first_seen + 32'd131071, 1'b1, 1'b0);
      wait_until_drained();
   endtask

   // Bursts from a pool of keys slightly larger than the table, plus random noise events.
   task automatic test_random_traffic(input int idle_send, input int stall_recv,
                                      input logic [pkfd_pkg::WINDOW_W-1:0] window,
                                      input logic [pkfd_pkg::COUNT_W-1:0] limit,
                                      input logic [pkfd_pkg::TIME_W-1:0] start_time,
                                      input int num_events);
      logic [pkfd_pkg::KEY_W-1:0]  key_pool [POOL_SIZE];
      logic [pkfd_pkg::KEY_W-1:0]  key;
      logic [pkfd_pkg::TIME_W-1:0] now_s;
      int                          sent;
      int                          burst;
      int                          roll;
      send_idle_pct  = idle_send;
      recv_stall_pct = stall_recv;
      write_csr(pkfd_pkg::REG_WINDOW_SECONDS, window);
      write_csr(pkfd_pkg::REG_ALERT_COUNT,
                {{(pkfd_pkg::CSR_W - pkfd_pkg::COUNT_W){1'b0}}, limit});
      for (int p = 0; p < POOL_SIZE; p++) begin
         key_pool[p] = {$urandom, $urandom};
      end
      key_pool[0] = '0;
      key_pool[1] = '1;
      now_s = start_time;
      sent = 0;
      while (sent < num_events) begin
         roll = $urandom_range(0, 99);
         if (roll < 85) begin
            key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            burst = (roll < 70) ? $urandom_range(1, int'(limit) + 2) : 1;
            repeat (burst) begin
               now_s = now_s + time_step();
               send_event(key, now_s, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
               sent++;
            end
         end else begin
            send_event({$urandom, $urandom}, $urandom, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
            sent++;
         end
      end
      wait_until_drained();
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset = 1'b0;
      test_alert_and_table_fill();
      test_zero_window_min_limit();
      test_count_saturation();
      test_random_traffic(19, 66, pkfd_pkg::WINDOW_W'($urandom_range(20, 300)),
                          pkfd_pkg::COUNT_W'($urandom_range(2, 8)), $urandom, 240);
      test_random_traffic(66, 19, pkfd_pkg::WINDOW_W'($urandom_range(0, 15)),
                          pkfd_pkg::COUNT_W'($urandom_range(1, 4)), $urandom, 240);
      test_random_traffic(0, 0, pkfd_pkg::WINDOW_W'($urandom_range(30, 120)),
                          pkfd_pkg::COUNT_W'($urandom_range(3, 12)), 32'hFFFF_F000, 230);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

/* per_key_flood_detector_core.f */
sv/pkfd_pkg.sv
sv/pkfd_entry_unit.sv
sv/pkfd_table.sv
sv/per_key_flood_detector_core.sv
test/tb_per_key_flood_detector_core.sv
